>>> rtl/core/chbf_pkg.sv
// Shared types and constants for the channel burst framer.
// Used by chbf_framer and channel_burst_framer; depends on nothing else.
`timescale 1ns / 1ps

package chbf_pkg;

    // Widths of the stream fields and the configuration register.
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int LIMIT_W = 10;

    // Most words a single input byte can cause: end, channel, data, control, end.
    localparam int MAX_WORDS = 5;
    localparam int COUNT_W   = $clog2(MAX_WORDS + 1);

    // Transmit FIFO word codes.
    localparam logic [WORD_W-1:0] WORD_CHAN = 16'h0200;
    localparam logic [WORD_W-1:0] WORD_CTL  = 16'h0100;
    localparam logic [WORD_W-1:0] WORD_END  = 16'h0400;

    // Reset value of the burst limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

    // Position within the message header, one-hot.
    typedef enum logic [3:0] {
        HDR_LO   = 4'b0001,
        HDR_HI   = 4'b0010,
        HDR_CTL  = 4'b0100,
        HDR_DATA = 4'b1000
    } hdr_pos_t;

    // Word list caused by one input byte; words[0] goes out first.
    typedef struct packed {
        logic [MAX_WORDS-1:0][WORD_W-1:0] words;
        logic [COUNT_W-1:0]               count;
    } frame_t;

endpackage

>>> rtl/core/chbf_framer.sv
// Message framing state and the word list each input byte produces.
// Depends on chbf_pkg.
`timescale 1ns / 1ps

module chbf_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_accept,
    input  logic [chbf_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last,
    input  logic [chbf_pkg::LIMIT_W-1:0]  burst_limit,
    output chbf_pkg::frame_t              frame
);
    import chbf_pkg::*;

    hdr_pos_t            hdr_reg, hdr_next;
    logic [WORD_W-1:0]   chan_reg, chan_next;
    logic [BYTE_W-1:0]   ctl_reg, ctl_next;
    logic [LIMIT_W-1:0]  rem_reg, rem_next;

    logic [LIMIT_W-1:0]  load_value;
    logic [BYTE_W-1:0]   ctl_now;
    logic                boundary;
    logic                in_body;

    // A zero limit behaves as a limit of one.
    assign load_value = (burst_limit == '0) ? LIMIT_W'(1) : burst_limit;

    assign in_body  = (hdr_reg == HDR_CTL) || (hdr_reg == HDR_DATA);
    assign boundary = (hdr_reg == HDR_DATA) && (rem_reg == '0);
    assign ctl_now  = (hdr_reg == HDR_CTL) ? data_byte : ctl_reg;

    // Next framing state for an accepted byte.
    always_comb begin
        hdr_next  = hdr_reg;
        chan_next = chan_reg;
        ctl_next  = ctl_reg;
        rem_next  = rem_reg;
        unique case (hdr_reg)
            HDR_LO: begin
                chan_next = {{(WORD_W - BYTE_W){1'b0}}, data_byte};
                hdr_next  = last ? HDR_LO : HDR_HI;
            end
            HDR_HI: begin
                chan_next = {data_byte, chan_reg[BYTE_W-1:0]};
                hdr_next  = last ? HDR_LO : HDR_CTL;
            end
            HDR_CTL: begin
                ctl_next  = data_byte;
                chan_next = chan_reg | WORD_CHAN;
                rem_next  = load_value;
                hdr_next  = last ? HDR_LO : HDR_DATA;
            end
            HDR_DATA: begin
                rem_next = (boundary ? load_value : rem_reg) - LIMIT_W'(1);
                hdr_next = last ? HDR_LO : HDR_DATA;
            end
            default: begin
                hdr_next = HDR_LO;
            end
        endcase
    end

    // Word list: each candidate word is appended in emission order.
    always_comb begin
        frame.words = '0;
        frame.count = '0;
        if (boundary) begin
            frame.words[frame.count] = WORD_END;
            frame.count              = frame.count + COUNT_W'(1);
        end
        if (boundary || (hdr_reg == HDR_CTL)) begin
            frame.words[frame.count] = chan_reg | WORD_CHAN;
            frame.count              = frame.count + COUNT_W'(1);
        end
        if (hdr_reg == HDR_DATA) begin
            frame.words[frame.count] = {{(WORD_W - BYTE_W){1'b0}}, data_byte};
            frame.count              = frame.count + COUNT_W'(1);
        end
        if (in_body && last && (ctl_now != '0)) begin
            frame.words[frame.count] = WORD_CTL | {{(WORD_W - BYTE_W){1'b0}}, ctl_now};
            frame.count              = frame.count + COUNT_W'(1);
        end
        if (in_body && last) begin
            frame.words[frame.count] = WORD_END;
            frame.count              = frame.count + COUNT_W'(1);
        end
    end

    // State registers advance only on an accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg  <= HDR_LO;
            chan_reg <= '0;
            ctl_reg  <= '0;
            rem_reg  <= '0;
        end else if (in_accept) begin
            hdr_reg  <= hdr_next;
            chan_reg <= chan_next;
            ctl_reg  <= ctl_next;
            rem_reg  <= rem_next;
        end
    end

    // A final byte always returns the header tracker to the low byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && last) |=> (hdr_reg == HDR_LO))
        else $error("header position not cleared after message end");

    // The stored channel word carries its marker once data bytes flow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (hdr_reg == HDR_DATA) |-> (chan_reg[9] == 1'b1))
        else $error("channel word lost its marker bit");

    // Channel address bytes never produce words.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((hdr_reg == HDR_LO) || (hdr_reg == HDR_HI)) |-> (frame.count == '0))
        else $error("words produced during channel address bytes");

endmodule

>>> rtl/core/channel_burst_framer.sv
// Top level of the channel burst framer: stream ports, burst limit register
// and the output word queue. Depends on chbf_pkg and chbf_framer.
`timescale 1ns / 1ps

// Frames messages arriving one byte per transfer (channel low, channel high,
// control, then data, last byte marked with s_tlast) into 16-bit transmit
// FIFO words. A byte is framed in the cycle it is accepted and its words
// (zero to five) go out one per cycle while m_tready is high, with m_tlast
// on the final word of each byte. Plain data bytes stream at one per cycle
// while m_tready is high; a byte that yields several words holds the output
// queue until they are all taken, and the next byte is accepted in the
// cycle its predecessor's last word is taken. Messages shorter than three
// bytes are dropped without output. The burst limit (cfg_data, reset 1023)
// is sampled when a burst starts and should be written while the block idles.
module channel_burst_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [chbf_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // last
    // Transmit FIFO word stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [chbf_pkg::WORD_W-1:0]   m_tdata,   // [15:0] fifo_word
    output logic                          m_tlast,   // run_last
    // Burst limit register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [chbf_pkg::LIMIT_W-1:0]  cfg_data   // [9:0] burst_limit
);
    import chbf_pkg::*;

    logic [LIMIT_W-1:0]                limit_reg;
    logic [MAX_WORDS-1:0][WORD_W-1:0]  words_reg;
    logic [COUNT_W-1:0]                count_reg;
    frame_t                            frame;
    logic                              in_accept;
    logic                              out_accept;

    // The register accepts a write in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= cfg_data;
        end
    end

    // Framing logic and header state.
    chbf_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .data_byte   (s_tdata),
        .last        (s_tlast),
        .burst_limit (limit_reg),
        .frame       (frame)
    );

    // A new byte enters when the queue is empty or its final word leaves now.
    assign s_tready   = (count_reg == '0) ||
                        ((count_reg == COUNT_W'(1)) && m_tready);
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = words_reg[0];
    assign m_tlast  = (count_reg == COUNT_W'(1));

    // Output queue: loads a byte's word list, shifts one word per transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (in_accept) begin
            count_reg <= frame.count;
        end else if (out_accept) begin
            count_reg <= count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            words_reg <= frame.words;
        end else if (out_accept) begin
            words_reg <= {{WORD_W{1'b0}}, words_reg[MAX_WORDS-1:1]};
        end
    end

    // The queue never holds more words than one byte can cause.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_WORDS))
        else $error("output queue count out of range");

    // A byte is only taken when no more than its predecessor's last word waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> (count_reg <= COUNT_W'(1)))
        else $error("byte accepted over pending words");

    // A byte that yields words presents its first word in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (frame.count != '0)) |=>
            (m_tvalid && (m_tdata == $past(frame.words[0]))))
        else $error("first word of a byte not presented");

endmodule
